// ----- rtl/core/fcte_pkg.sv -----
`default_nettype none
package fcte_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 4096;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned HOPS_W   = 16;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned LIMIT_W  = 12;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_READ  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEEK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADLINK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DEPTH   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARK  = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 12'd4094;
    localparam logic [DATA_W-1:0]  THRESHOLD_RST = 32'h0FFF_FFF8;
    localparam logic [DATA_W-1:0]  VALID_MAX_RST = 32'h0FFF_FFF7;
    localparam logic [DATA_W-1:0]  END_MARK_RST  = 32'h0FFF_FFFF;

endpackage
`default_nettype wire

// ----- rtl/core/fcte_ram.sv -----
`default_nettype none
module fcte_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/fat_cluster_table_engine.sv -----
`default_nettype none
// Channel   Direction  Handshake           Payload
// command   in         start & !busy       i_mode, i_cluster, i_value, i_hop_count
// result    out        o_done (one cycle)  o_result, o_status
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// Read/write/free: a pass-through or out-of-range cluster is answered without a RAM read, else
// one RAM read, then write-back for write or free. Allocate: scan reads one entry per cycle from
// index 0 and marks the first free entry with the end mark; a full table returns ST_FULL.
// Seek/find-end: a link held in the table is read from the single RAM port (S_WALK, then S_WDATA),
// a pass-through link is taken in S_WALK; the hop count (seek) or the depth limit can end the walk.
// After reset a clearing pass zeroes the table; busy stays high.
// The result register is independent of the command side; the receiver cannot stall.
module fat_cluster_table_engine #(
    parameter int unsigned TABLE_ENTRIES = fcte_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [fcte_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [fcte_pkg::DATA_W-1:0]       i_cluster,
    input  wire logic [fcte_pkg::DATA_W-1:0]       i_value,
    input  wire logic [fcte_pkg::HOPS_W-1:0]       i_hop_count,
    output logic                                   o_done,
    output logic      [fcte_pkg::DATA_W-1:0]       o_result,
    output logic      [fcte_pkg::STATUS_W-1:0]     o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [fcte_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fcte_pkg::DATA_W-1:0]       i_cfg_data
);
    import fcte_pkg::*;

    localparam int unsigned AW    = $clog2(TABLE_ENTRIES);
    localparam int unsigned IDX_W = AW + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_WDATA = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [AW-1:0]       r_pidx, n_pidx;
    logic                r_pend, n_pend;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [DATA_W-1:0]   r_cur, n_cur;
    logic [DATA_W-1:0]   r_value, n_value;
    logic [HOPS_W-1:0]   r_hops, n_hops;
    logic [DATA_W-1:0]   r_result, n_result;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_done, n_done;

    logic [LIMIT_W-1:0]  r_cfg_limit;
    logic [DATA_W-1:0]   r_cfg_thr;
    logic [DATA_W-1:0]   r_cfg_vmax;
    logic [DATA_W-1:0]   r_cfg_end;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;

    logic                in_hit;
    logic                cur_hit;
    logic                take;
    logic [DATA_W-1:0]   link;

    // Cluster maps onto a real table entry (not passed through, not out of range).
    function automatic logic entry_hit(input logic [DATA_W-1:0] c,
                                       input logic [DATA_W-1:0] thr,
                                       input logic [LIMIT_W-1:0] lim);
        logic below_thr;
        logic in_limit;
        logic in_table;
        below_thr = c < thr;
        in_limit  = {1'b0, c} <= ({{(DATA_W-LIMIT_W+1){1'b0}}, lim} + 33'd1);
        in_table  = {1'b0, c} < 33'(TABLE_ENTRIES);
        return below_thr && in_limit && in_table;
    endfunction

    fcte_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign in_hit  = entry_hit(i_cluster, r_cfg_thr, r_cfg_limit);
    assign cur_hit = entry_hit(r_cur, r_cfg_thr, r_cfg_limit);

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;
    assign o_status = r_status;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_mode    = r_mode;
        n_cur     = r_cur;
        n_value   = r_value;
        n_hops    = r_hops;
        n_result  = r_result;
        n_status  = r_status;
        n_done    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_cur[AW-1:0];
        ram_wdata = '0;
        take      = 1'b0;
        link      = '0;

        case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_idx[AW-1:0];
                n_idx    = r_idx + 1'b1;
                if (r_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_addr = i_cluster[AW-1:0];
                if (start) begin
                    n_mode  = i_mode;
                    n_cur   = i_cluster;
                    n_value = i_value;
                    n_hops  = i_hop_count;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    case (i_mode)
                        MODE_READ, MODE_WRITE, MODE_FREE: begin
                            if (i_cluster >= r_cfg_thr) begin
                                n_result = i_cluster;
                                n_status = ST_OK;
                                n_done   = 1'b1;
                            end else if (!in_hit) begin
                                n_result = '0;
                                n_status = ST_OK;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_ACC;
                            end
                        end
                        MODE_ALLOC: begin
                            n_state = S_ALLOC;
                        end
                        MODE_SEEK, MODE_FIND: begin
                            n_state = S_WALK;
                        end
                        default: begin
                            n_result = '0;
                            n_status = ST_OK;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end
            S_ACC: begin
                n_result = ram_rdata;
                n_status = ST_OK;
                n_done   = 1'b1;
                n_state  = S_IDLE;
                if (r_mode == MODE_WRITE) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_value;
                end else if (r_mode == MODE_FREE) begin
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                end
            end
            S_ALLOC: begin
                // read of entry r_idx is issued while entry r_pidx is checked
                if (r_pend && (ram_rdata == '0)) begin
                    ram_we    = 1'b1;
                    ram_addr  = r_pidx;
                    ram_wdata = r_cfg_end;
                    n_result  = DATA_W'(r_pidx);
                    n_status  = ST_OK;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_idx == IDX_W'(TABLE_ENTRIES)) begin
                    n_result = '0;
                    n_status = ST_FULL;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    ram_addr = r_idx[AW-1:0];
                    n_pidx   = r_idx[AW-1:0];
                    n_pend   = 1'b1;
                    n_idx    = r_idx + 1'b1;
                end
            end
            S_WALK: begin
                if ((r_mode == MODE_SEEK) && (r_hops == '0)) begin
                    n_result = r_cur;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_idx == IDX_W'(TABLE_ENTRIES)) begin
                    n_result = r_cur;
                    n_status = ST_DEPTH;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_cur >= r_cfg_thr) begin
                    take = 1'b1;
                    link = r_cur;
                end else if (!cur_hit) begin
                    take = 1'b1;
                    link = '0;
                end else begin
                    n_state = S_WDATA;
                end
            end
            S_WDATA: begin
                take = 1'b1;
                link = ram_rdata;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (take) begin
            n_state = S_WALK;
            n_idx   = r_idx + 1'b1;
            n_cur   = link;
            if (r_mode == MODE_SEEK) begin
                n_hops = r_hops - 1'b1;
                if (link >= r_cfg_vmax) begin
                    n_result = link;
                    n_status = ST_BADLINK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end else begin
                if (link == r_cfg_end) begin
                    n_result = r_cur;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (link >= r_cfg_vmax) begin
                    n_result = link;
                    n_status = ST_BADLINK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_done      <= 1'b0;
            r_cfg_limit <= LIMIT_RST;
            r_cfg_thr   <= THRESHOLD_RST;
            r_cfg_vmax  <= VALID_MAX_RST;
            r_cfg_end   <= END_MARK_RST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_done  <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIMIT:     r_cfg_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_THRESHOLD: r_cfg_thr   <= i_cfg_data;
                    CFG_VALID_MAX: r_cfg_vmax  <= i_cfg_data;
                    CFG_END_MARK:  r_cfg_end   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_mode   <= n_mode;
        r_cur    <= n_cur;
        r_value  <= n_value;
        r_hops   <= n_hops;
        r_result <= n_result;
        r_status <= n_status;
    end

    // a completed transaction always returns the engine to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while engine still busy");

    // table writes only from clearing, single access write-back, or allocation
    a_no_walk_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) || (r_state == S_ACC) || (r_state == S_ALLOC)))
        else $error("table write during a chain walk");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(TABLE_ENTRIES))
        else $error("entry counter past table depth");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_status == ST_FULL)) |-> (r_result == '0))
        else $error("full status with nonzero result");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && (r_idx == IDX_W'(TABLE_ENTRIES - 1))) |=> (r_state == S_IDLE))
        else $error("clearing pass did not end at last entry");

endmodule
`default_nettype wire
